// ===== sv/gsvl_pkg.sv =====
// ----------------------------------------------------------------------------
// gsvl_pkg
// Shared widths, register indexes and corner tables of the simplex vertex
// locator.
// ----------------------------------------------------------------------------
package gsvl_pkg;

  localparam int unsigned ID_W         = 33;
  localparam int unsigned CORNER_W     = 2;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned VIDX_W       = 30;
  localparam int unsigned SIZE_CFG_W   = 11;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned SUB_W        = 3;
  localparam int unsigned MAX_AXIS_DEF = 1024;

  localparam int unsigned IN_DATA_W  = 40;  // 33 + 2 bits, padded to bytes
  localparam int unsigned OUT_DATA_W = 80;  // 16 + 16 + 16 + 30 bits, padded

  // simplices per grid cell
  localparam logic [SUB_W-1:0] TETS_PER_CUBE   = 3'd6;
  localparam logic [SUB_W-1:0] TRIS_PER_SQUARE = 3'd2;

  // corner offset code: bit0 = +x, bit1 = +y, bit2 = +z
  localparam logic [2:0] CORNER_ALL = 3'd7;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THREE_DIMS = 3'd0,
    REG_SIZE_X     = 3'd1,
    REG_SIZE_Y     = 3'd2,
    REG_START_X    = 3'd3,
    REG_START_Y    = 3'd4,
    REG_START_Z    = 3'd5
  } cfg_reg_e;

  // cube-corner offset of one simplex corner
  function automatic logic [2:0] corner_offset(input logic three_dims,
                                               input logic [SUB_W-1:0] sub,
                                               input logic [CORNER_W-1:0] corner);
    logic [2:0] off;
    off = 3'd0;
    if (three_dims) begin
      case ({sub, corner})
        5'b000_00: off = 3'd2;
        5'b000_01: off = 3'd3;
        5'b000_10: off = 3'd0;
        5'b000_11: off = CORNER_ALL;
        5'b001_00: off = 3'd2;
        5'b001_01: off = 3'd0;
        5'b001_10: off = 3'd6;
        5'b001_11: off = CORNER_ALL;
        5'b010_00: off = 3'd3;
        5'b010_01: off = 3'd0;
        5'b010_10: off = 3'd1;
        5'b010_11: off = CORNER_ALL;
        5'b011_00: off = 3'd0;
        5'b011_01: off = 3'd1;
        5'b011_10: off = CORNER_ALL;
        5'b011_11: off = 3'd5;
        5'b100_00: off = 3'd0;
        5'b100_01: off = 3'd6;
        5'b100_10: off = CORNER_ALL;
        5'b100_11: off = 3'd4;
        5'b101_00: off = 3'd0;
        5'b101_01: off = CORNER_ALL;
        5'b101_10: off = 3'd4;
        5'b101_11: off = 3'd5;
        default:   off = 3'd0;
      endcase
    end else begin
      // triangles: fourth corner repeats the first
      case ({sub[0], corner})
        3'b0_01: off = 3'd1;
        3'b0_10: off = 3'd3;
        3'b1_01: off = 3'd2;
        3'b1_10: off = 3'd3;
        default: off = 3'd0;
      endcase
    end
    return off;
  endfunction

endpackage

// ===== sv/gsvl_div.sv =====
// ----------------------------------------------------------------------------
// gsvl_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside each transaction.
// ----------------------------------------------------------------------------
module gsvl_div #(
  parameter int unsigned N  = 33,
  parameter int unsigned DW = 34,
  parameter int unsigned SW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  logic [N-1:0]  dvd_i,
  input  logic [DW-1:0] dvs_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [N-1:0]  quo_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          v_q    [N];
  logic [DW-1:0] rem_q  [N];
  logic [N-1:0]  acc_q  [N];
  logic [SW-1:0] side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [N-1:0]  acc_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_d;
    logic [N-1:0]  acc_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign acc_in  = dvd_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign acc_in  = acc_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      trial = {rem_in, acc_in[N-1]};
      diff  = trial - {1'b0, dvs_i};
      if (trial >= {1'b0, dvs_i}) begin
        rem_d = diff[DW-1:0];
        acc_d = {acc_in[N-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        acc_d = {acc_in[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= rem_d;
        acc_q[k]  <= acc_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign quo_o   = acc_q[N-1];
  assign rem_o   = rem_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// ===== sv/grid_simplex_vertex_locator.sv =====
// ----------------------------------------------------------------------------
// grid_simplex_vertex_locator
// Turns a simplex cell id and corner number into the corner's global grid
// coordinates and its linear vertex index within the local block.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the output is not stalled, and one
// result leaves per transaction, in order. The path is the input register,
// 33 + 33 stages of the two chained bit-per-stage dividers for cube plane and
// cube row, two stages that split the simplex within the cube by a reciprocal
// multiply, one coordinate stage and the output register. A stall on the
// output side freezes the whole pipeline. Configuration registers feed the
// pipeline, so they must be written only with the pipeline empty; the block
// itself does not enforce this. Sizes are clamped to 2..MAX_AXIS; in 2D mode
// point_z reads zero.
module grid_simplex_vertex_locator #(
  parameter int unsigned MAX_AXIS = gsvl_pkg::MAX_AXIS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [gsvl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gsvl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: cell_id[32:0], corner[34:33], zero pad
  input  logic [gsvl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: point_x[15:0], point_y[31:16], point_z[47:32],
  //        vertex_index[77:48], zero pad
  output logic [gsvl_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned SZW  = $clog2(MAX_AXIS + 1);
  localparam int unsigned RW   = SZW + 3;
  localparam int unsigned PW   = 2 * SZW + 3;
  localparam int unsigned DW1  = gsvl_pkg::ID_W + 1;
  localparam int unsigned IDW  = gsvl_pkg::ID_W;
  localparam int unsigned VW   = gsvl_pkg::VIDX_W;
  localparam int unsigned CW   = gsvl_pkg::COORD_W;
  localparam int unsigned KW   = gsvl_pkg::CORNER_W;
  localparam int unsigned SUBW = gsvl_pkg::SUB_W;

  // x / 3 == (x * 0xAAAB) >> 17 for any x below 2**16
  localparam logic [15:0] RECIP3    = 16'hAAAB;
  localparam int unsigned RECIP3_SH = 17;

  // configuration registers
  logic                              three_dims_q;
  logic [gsvl_pkg::SIZE_CFG_W-1:0]   size_x_q, size_y_q;
  logic [CW-1:0]                     start_x_q, start_y_q, start_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_dims_q <= 1'b1;
      size_x_q     <= gsvl_pkg::SIZE_CFG_W'(2);
      size_y_q     <= gsvl_pkg::SIZE_CFG_W'(2);
      start_x_q    <= '0;
      start_y_q    <= '0;
      start_z_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gsvl_pkg::REG_THREE_DIMS: three_dims_q <= cfg_data_i[0];
        gsvl_pkg::REG_SIZE_X:     size_x_q <= cfg_data_i[gsvl_pkg::SIZE_CFG_W-1:0];
        gsvl_pkg::REG_SIZE_Y:     size_y_q <= cfg_data_i[gsvl_pkg::SIZE_CFG_W-1:0];
        gsvl_pkg::REG_START_X:    start_x_q <= cfg_data_i;
        gsvl_pkg::REG_START_Y:    start_y_q <= cfg_data_i;
        gsvl_pkg::REG_START_Z:    start_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped sizes and derived divisors
  logic [SZW-1:0]   sx_d, sy_d, sx_q;
  logic [RW-1:0]    row_d, row_q;
  logic [PW-1:0]    plane_d, plane_q;
  logic [2*SZW-1:0] sxy_d, sxy_q;
  logic [2*SZW-1:0] cell_area;

  always_comb begin
    if (size_x_q < gsvl_pkg::SIZE_CFG_W'(2)) begin
      sx_d = SZW'(2);
    end else if (32'(size_x_q) > MAX_AXIS) begin
      sx_d = SZW'(MAX_AXIS);
    end else begin
      sx_d = SZW'(size_x_q);
    end
    if (size_y_q < gsvl_pkg::SIZE_CFG_W'(2)) begin
      sy_d = SZW'(2);
    end else if (32'(size_y_q) > MAX_AXIS) begin
      sy_d = SZW'(MAX_AXIS);
    end else begin
      sy_d = SZW'(size_y_q);
    end
    cell_area = (2*SZW)'(sx_d - 1'b1) * (2*SZW)'(sy_d - 1'b1);
    plane_d   = (PW'(cell_area) << 2) + (PW'(cell_area) << 1);
    if (three_dims_q) begin
      row_d = (RW'(sx_d - 1'b1) << 2) + (RW'(sx_d - 1'b1) << 1);
    end else begin
      row_d = RW'(sx_d - 1'b1) << 1;
    end
    sxy_d = (2*SZW)'(sx_d) * (2*SZW)'(sy_d);
  end

  always_ff @(posedge clk_i) begin
    sx_q    <= sx_d;
    row_q   <= row_d;
    plane_q <= plane_d;
    sxy_q   <= sxy_d;
  end

  // pipeline advance: everything moves unless the output is held
  logic adv;
  logic out_v_q;

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  // input capture stage
  logic           in_v_q;
  logic [IDW-1:0] in_id_q;
  logic [KW-1:0]  in_corner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_id_q     <= s_axis_tdata[IDW-1:0];
      in_corner_q <= s_axis_tdata[IDW+KW-1:IDW];
    end
  end

  // cube layer: id / plane; in 2D the divisor exceeds any id
  logic [DW1-1:0] dvs1;
  logic           d1_v;
  logic [IDW-1:0] d1_quo;
  logic [DW1-1:0] d1_rem;
  logic [KW-1:0]  d1_side;

  assign dvs1 = three_dims_q ? DW1'(plane_q) : (DW1'(1) << IDW);

  gsvl_div #(.N(IDW), .DW(DW1), .SW(KW)) u_div_plane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_v_q),
    .dvd_i   (in_id_q),
    .dvs_i   (dvs1),
    .side_i  (in_corner_q),
    .valid_o (d1_v),
    .quo_o   (d1_quo),
    .rem_o   (d1_rem),
    .side_o  (d1_side)
  );

  // cube row: remainder / row
  logic             d2_v;
  logic [IDW-1:0]   d2_quo;
  logic [RW-1:0]    d2_rem;
  logic [VW+KW-1:0] d2_side;

  gsvl_div #(.N(IDW), .DW(RW), .SW(VW+KW)) u_div_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (d1_v),
    .dvd_i   (d1_rem[IDW-1:0]),
    .dvs_i   (row_q),
    .side_i  ({d1_quo[VW-1:0], d1_side}),
    .valid_o (d2_v),
    .quo_o   (d2_quo),
    .rem_o   (d2_rem),
    .side_o  (d2_side)
  );

  // cube column and simplex number: remainder / simplices per cube,
  // quotient from a reciprocal multiply (a shift in 2D), remainder one stage later
  logic [SUBW-1:0]    dvs3;
  logic [RW-1:0]      half_rem;
  logic [RW+15:0]     recip_prod;
  logic [RW-1:0]      quo3_d;
  logic [RW-1:0]      dq_mult;
  logic               dq_v_q;
  logic [RW-1:0]      dq_quo_q, dq_num_q;
  logic [2*VW+KW-1:0] dq_side_q;
  logic               d3_v_q;
  logic [RW-1:0]      d3_quo_q;
  logic [SUBW-1:0]    d3_rem_q;
  logic [2*VW+KW-1:0] d3_side_q;

  assign dvs3       = three_dims_q ? gsvl_pkg::TETS_PER_CUBE : gsvl_pkg::TRIS_PER_SQUARE;
  assign half_rem   = d2_rem >> 1;
  assign recip_prod = (RW+16)'(half_rem) * (RW+16)'(RECIP3);
  assign quo3_d     = three_dims_q ? RW'(recip_prod >> RECIP3_SH) : half_rem;
  assign dq_mult    = RW'(dq_quo_q * RW'(dvs3));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_v_q <= 1'b0;
      d3_v_q <= 1'b0;
    end else if (adv) begin
      dq_v_q <= d2_v;
      d3_v_q <= dq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dq_quo_q  <= quo3_d;
      dq_num_q  <= d2_rem;
      dq_side_q <= {d2_quo[VW-1:0], d2_side};
      d3_quo_q  <= dq_quo_q;
      d3_rem_q  <= SUBW'(dq_num_q - dq_mult);
      d3_side_q <= dq_side_q;
    end
  end

  // corner offset, global coordinates and index products
  logic [2:0]    off;
  logic [KW-1:0] corner;
  logic [VW-1:0] cx_d, cy_d, cz_d;
  logic [VW-1:0] cz_raw, cy_raw;

  assign corner = d3_side_q[KW-1:0];
  assign cz_raw = d3_side_q[VW+KW-1:KW];
  assign cy_raw = d3_side_q[2*VW+KW-1:VW+KW];
  assign off    = gsvl_pkg::corner_offset(three_dims_q, d3_rem_q, corner);
  assign cx_d   = VW'(d3_quo_q) + VW'(off[0]);
  assign cy_d   = cy_raw + VW'(off[1]);
  assign cz_d   = cz_raw + VW'(off[2]);

  logic          a_v_q;
  logic [CW-1:0] a_px_q, a_py_q, a_pz_q;
  logic [VW-1:0] a_cx_q, a_row_q, a_plane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= d3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_px_q    <= start_x_q + cx_d[CW-1:0];
      a_py_q    <= start_y_q + cy_d[CW-1:0];
      a_pz_q    <= three_dims_q ? (start_z_q + cz_d[CW-1:0]) : '0;
      a_cx_q    <= cx_d;
      a_row_q   <= VW'(cy_d * VW'(sx_q));
      a_plane_q <= VW'(cz_d * VW'(sxy_q));
    end
  end

  // output register: vertex index sum
  logic [CW-1:0] out_px_q, out_py_q, out_pz_q;
  logic [VW-1:0] out_vi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_px_q <= a_px_q;
      out_py_q <= a_py_q;
      out_pz_q <= a_pz_q;
      out_vi_q <= a_cx_q + a_row_q + a_plane_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(gsvl_pkg::OUT_DATA_W - 3*CW - VW)'(0),
                          out_vi_q, out_pz_q, out_py_q, out_px_q};

endmodule
